>>> src/bksl_pkg.sv
`default_nettype none

package bksl_pkg;

   localparam int MAX_K  = 16;
   localparam int CNT_W  = $clog2(MAX_K + 1);
   localparam int IDX_W  = $clog2(MAX_K);
   localparam int REF_W  = 16;
   localparam int DIST_W = 32;
   localparam int KLIM_W = 5;

   localparam logic [KLIM_W-1:0] K_LIMIT_RESET = KLIM_W'(16);

   // What one cell shows to its upper neighbor.
   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic [REF_W-1:0]  ptr;
      logic              valid;
      logic              le;     // valid and holds a distance <= the candidate
   } link_type;

   // Broadcast to every cell of the row.
   typedef struct packed {
      logic              insert;
      logic              clear;
      logic              kept;
      logic [DIST_W-1:0] distance;
      logic [REF_W-1:0]  ptr;
   } cell_cmd_type;

endpackage

`default_nettype wire

>>> src/bounded_k_smallest_list_unit.sv
`default_nettype none

// Channel   Dir  Beat on          Payload
// req       in   tvalid & tready  tuser: req_type; tdata: point_ref, distance
// rsp       out  tvalid & tready  tuser: entry_valid, kept; tdata: point, dist, count
// csr       in   csr_we           csr_wdata: k_limit
//
// An insert updates the whole cell row at once; its report is then loaded
// into the output register from the report state once the output slot is
// free, and no new request is taken until that report is loaded.
// A drain of n entries gives n beats (one empty beat for an empty list),
// one beat per cycle unless stalled, through the cell row's single read port.
// Reset is synchronous and empties the list; k_limit returns to 16.
// A stalled output holds the current beat and delays the next load only.

module bounded_k_smallest_list_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // [15:0] point_ref, [47:16] distance
   input  wire logic [0:0]  req_tuser,   // [0] req_type
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata,   // [15:0] point_out, [47:16] dist_out,
                                         // [52:48] count_out, [55:53] zero
   output logic [1:0]       rsp_tuser,   // [0] entry_valid, [1] kept
   output logic             rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic [bksl_pkg::KLIM_W-1:0] csr_wdata
);
   import bksl_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REPORT,
      ST_DRAIN
   } state_type;

   localparam logic REQ_INSERT = 1'b0;

   state_type         state_ff, state_in;
   logic [KLIM_W-1:0] k_limit_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              kept_ff, kept_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [REF_W-1:0]  rsp_ptr_ff, rsp_ptr_in;
   logic [DIST_W-1:0] rsp_dist_ff, rsp_dist_in;
   logic [CNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic              rsp_entry_ff, rsp_entry_in;
   logic              rsp_kept_ff, rsp_kept_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [CNT_W-1:0]  k_eff;
   logic [REF_W-1:0]  req_ptr;
   logic [DIST_W-1:0] req_dist;
   logic              accept, slot_free, kept_now;
   logic [CNT_W-1:0]  p_pos, kept_cnt;
   logic [MAX_K-1:0]  le_vec, valid_vec, below_vec;
   logic [IDX_W-1:0]  rd_idx;
   link_type          links [MAX_K];
   link_type          prev_links [MAX_K];
   link_type          rd_link;
   cell_cmd_type      cmd;

   assign req_ptr  = req_tdata[REF_W-1:0];
   assign req_dist = req_tdata[REF_W+DIST_W-1:REF_W];
   assign k_eff    = (CNT_W'(k_limit_ff) > CNT_W'(MAX_K)) ? CNT_W'(MAX_K)
                                                           : CNT_W'(k_limit_ff);

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   // Cell row: each cell sees its lower neighbor; the bottom cell sees a
   // neighbor that is always valid and never above the candidate.
   for (genvar i = 0; i < MAX_K; i++) begin : g_row
      if (i == 0) begin : g_first
         assign prev_links[i] = '{distance: '0, ptr: '0, valid: 1'b1, le: 1'b1};
      end else begin : g_next
         assign prev_links[i] = links[i-1];
      end
      assign below_vec[i] = (CNT_W'(i) < k_eff);
      assign le_vec[i]    = links[i].le;
      assign valid_vec[i] = links[i].valid;

      bksl_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .cmd     (cmd),
         .prev    (prev_links[i]),
         .below_k (below_vec[i]),
         .self    (links[i])
      );
   end

   // The candidate is kept if some slot under the limit is not at or below it.
   assign kept_now = |(~le_vec & below_vec);

   // The le flags form a run from the bottom cell; its length is the
   // insert position.
   always_comb begin
      p_pos = '0;
      for (int i = 0; i < MAX_K; i++) begin
         if (le_vec[i]) begin
            p_pos = CNT_W'(i + 1);
         end
      end
   end

   assign kept_cnt = (count_ff < k_eff) ? count_ff + CNT_W'(1) : k_eff;

   always_comb begin
      cmd.insert   = accept && (req_tuser[0] == REQ_INSERT);
      cmd.clear    = 1'b0;
      cmd.kept     = kept_now;
      cmd.distance = req_dist;
      cmd.ptr      = req_ptr;
      if (state_ff == ST_DRAIN && slot_free && count_ff != '0 && idx_ff == '0) begin
         cmd.clear = 1'b1;
      end
   end

   assign rd_idx  = (state_ff == ST_DRAIN) ? idx_ff : IDX_W'(count_ff - CNT_W'(1));
   assign rd_link = links[rd_idx];

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      kept_in      = kept_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_ptr_in   = rsp_ptr_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_count_in = rsp_count_ff;
      rsp_entry_in = rsp_entry_ff;
      rsp_kept_in  = rsp_kept_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser[0] == REQ_INSERT) begin
                  kept_in  = kept_now;
                  count_in = kept_now ? kept_cnt : p_pos;
                  state_in = ST_REPORT;
               end else begin
                  idx_in   = IDX_W'(count_ff - CNT_W'(1));
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_REPORT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_entry_in = (count_ff != '0);
               rsp_ptr_in   = (count_ff != '0) ? rd_link.ptr : '0;
               rsp_dist_in  = (count_ff != '0) ? rd_link.distance : '0;
               rsp_kept_in  = kept_ff;
               rsp_count_in = count_ff;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_DRAIN: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_kept_in  = 1'b0;
               rsp_count_in = '0;
               if (count_ff == '0) begin
                  rsp_entry_in = 1'b0;
                  rsp_ptr_in   = '0;
                  rsp_dist_in  = '0;
                  rsp_last_in  = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  rsp_entry_in = 1'b1;
                  rsp_ptr_in   = rd_link.ptr;
                  rsp_dist_in  = rd_link.distance;
                  rsp_last_in  = (idx_ff == '0);
                  if (idx_ff == '0) begin
                     count_in = '0;
                     state_in = ST_IDLE;
                  end else begin
                     idx_in = idx_ff - IDX_W'(1);
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         k_limit_ff   <= K_LIMIT_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            k_limit_ff <= csr_wdata;
         end
      end
      idx_ff       <= idx_in;
      kept_ff      <= kept_in;
      rsp_ptr_ff   <= rsp_ptr_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_count_ff <= rsp_count_in;
      rsp_entry_ff <= rsp_entry_in;
      rsp_kept_ff  <= rsp_kept_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_count_ff, rsp_dist_ff, rsp_ptr_ff};
   assign rsp_tuser  = {rsp_kept_ff, rsp_entry_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_K))
      else $error("entry count above capacity");

   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      (valid_vec & (valid_vec + MAX_K'(1))) == '0)
      else $error("valid cells do not form a run from the bottom");

   a_valid_count: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == 32'(count_ff))
      else $error("valid cells disagree with entry count");

   a_drain_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN && count_ff != '0) |-> (CNT_W'(idx_ff) < count_ff))
      else $error("drain index outside held entries");

   a_insert_report: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser[0] == REQ_INSERT) |=> (state_ff == ST_REPORT))
      else $error("insert did not move to report");
`endif

endmodule

`default_nettype wire

>>> src/bksl_cell.sv
`default_nettype none

module bksl_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire bksl_pkg::cell_cmd_type cmd,
   input  wire bksl_pkg::link_type    prev,
   input  wire logic                  below_k,
   output bksl_pkg::link_type         self
);
   import bksl_pkg::*;

   logic [DIST_W-1:0] dist_ff, dist_in;
   logic [REF_W-1:0]  ptr_ff, ptr_in;
   logic              valid_ff, valid_in;
   logic              le;

   assign le = valid_ff && (dist_ff <= cmd.distance);

   always_comb begin
      dist_in  = dist_ff;
      ptr_in   = ptr_ff;
      valid_in = valid_ff;
      if (cmd.clear) begin
         valid_in = 1'b0;
      end else if (cmd.insert) begin
         // Entries at or below the candidate stay, the slot just above them
         // takes the candidate, and everything higher moves up by one.
         if (!le) begin
            if (prev.le) begin
               dist_in = cmd.distance;
               ptr_in  = cmd.ptr;
            end else begin
               dist_in = prev.distance;
               ptr_in  = prev.ptr;
            end
         end
         if (cmd.kept) begin
            valid_in = (valid_ff || prev.valid) && below_k;
         end else begin
            valid_in = le;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      dist_ff <= dist_in;
      ptr_ff  <= ptr_in;
   end

   assign self.distance = dist_ff;
   assign self.ptr      = ptr_ff;
   assign self.valid    = valid_ff;
   assign self.le       = le;

endmodule

`default_nettype wire
